### rtl/utf16_to_utf8_encoder_assert.svh
// Assertion macros used by the checker file of the transcoder.
`ifndef UTF16_TO_UTF8_ENCODER_ASSERT_SVH
`define UTF16_TO_UTF8_ENCODER_ASSERT_SVH

// Checked at every clock edge once reset has been released.
`define U8_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define U8_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/u16u8_pkg.sv
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CP_W        = 21;

    localparam logic [7:0]      LEAD2     = 8'hC0;
    localparam logic [7:0]      CONT      = 8'h80;
    localparam logic [7:0]      LEAD3     = 8'hE0;
    localparam logic [7:0]      LEAD4     = 8'hF0;
    localparam logic [CP_W-1:0] LIMIT1    = 21'h00080;
    localparam logic [CP_W-1:0] LIMIT2    = 21'h00800;
    localparam logic [CP_W-1:0] LIMIT3    = 21'h10000;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_string;
    } unit_item_t;

    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       last_of_char;
    } byte_item_t;

    // One character waiting to be serialized: bytes in send order, byte 0 first.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } char_entry_t;

    function automatic char_entry_t encode_point(input logic [CP_W-1:0] cp);
        char_entry_t e;
        e.bytes = '0;
        if (cp < LIMIT1) begin
            e.bytes[0] = cp[7:0];
            e.last_idx = 2'd0;
        end
        else if (cp < LIMIT2) begin
            e.bytes[0] = LEAD2 | {3'b000, cp[10:6]};
            e.bytes[1] = CONT | {2'b00, cp[5:0]};
            e.last_idx = 2'd1;
        end
        else if (cp < LIMIT3) begin
            e.bytes[0] = LEAD3 | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT | {2'b00, cp[11:6]};
            e.bytes[2] = CONT | {2'b00, cp[5:0]};
            e.last_idx = 2'd2;
        end
        else begin
            e.bytes[0] = LEAD4 | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT | {2'b00, cp[17:12]};
            e.bytes[2] = CONT | {2'b00, cp[11:6]};
            e.bytes[3] = CONT | {2'b00, cp[5:0]};
            e.last_idx = 2'd3;
        end
        return e;
    endfunction

endpackage

### rtl/u16u8_front.sv
module u16u8_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  u16u8_pkg::unit_item_t   unit_item,
    output logic                    q_push,
    input  logic                    q_full,
    output u16u8_pkg::char_entry_t  q_data
);
    import u16u8_pkg::*;

    logic              held_reg;
    logic              held_next;
    logic [15:0]       high_unit_reg;
    logic [15:0]       high_unit_next;
    logic              accept;
    logic              is_high;
    logic [CP_W-1:0]   cp;
    logic              has_output;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        is_high        = unit_item.code_unit inside {[16'hD800:16'hDBFF]};
        held_next      = held_reg;
        high_unit_next = high_unit_reg;
        has_output     = 1'b0;
        cp             = {5'b00000, unit_item.code_unit};
        if (held_reg) begin
            // The following unit is paired without checking that it is a low surrogate.
            cp = {1'b0, high_unit_reg[9:0], unit_item.code_unit[9:0]} + SUPP_BASE;
            has_output = 1'b1;
            if (accept) begin
                held_next      = 1'b0;
                high_unit_next = '0;
            end
        end
        else if (is_high && !unit_item.end_of_string) begin
            if (accept) begin
                held_next      = 1'b1;
                high_unit_next = unit_item.code_unit;
            end
        end
        else begin
            has_output = unit_item.code_unit != 16'h0000;
        end
    end

    assign q_push = accept && has_output;
    assign q_data = encode_point(cp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg      <= 1'b0;
            high_unit_reg <= '0;
        end
        else begin
            held_reg      <= held_next;
            high_unit_reg <= high_unit_next;
        end
    end

endmodule

### rtl/u16u8_queue.sv
module u16u8_queue #(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  u16u8_pkg::char_entry_t  wr_data,
    output logic                    full,
    input  logic                    rd_en,
    output u16u8_pkg::char_entry_t  rd_data,
    output logic                    empty
);
    import u16u8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    char_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_wr;
    logic               do_rd;

    assign full    = count_reg == CNT_W'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### rtl/u16u8_back.sv
module u16u8_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  u16u8_pkg::char_entry_t  q_data,
    output logic                    q_pop,
    output logic                    empty,
    input  logic                    pop,
    output u16u8_pkg::byte_item_t   byte_item
);
    import u16u8_pkg::*;

    char_entry_t  cur_reg;
    char_entry_t  cur_next;
    logic         cur_valid_reg;
    logic         cur_valid_next;
    logic [1:0]   idx_reg;
    logic [1:0]   idx_next;
    byte_item_t   out_reg;
    byte_item_t   out_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         advance;
    logic         cur_last;

    // A byte moves into the output register whenever that register is free or being drained.
    assign advance  = cur_valid_reg && (!out_valid_reg || pop);
    assign cur_last = idx_reg == cur_reg.last_idx;
    assign q_pop    = !q_empty && (!cur_valid_reg || (advance && cur_last));

    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (advance) begin
            out_valid_next         = 1'b1;
            out_next.utf8_byte     = cur_reg.bytes[idx_reg];
            out_next.last_of_char  = cur_last;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end

        if (q_pop) begin
            cur_next       = q_data;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (advance && cur_last) begin
            cur_valid_next = 1'b0;
        end
        else if (advance) begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    assign empty     = !out_valid_reg;
    assign byte_item = out_reg;

endmodule

### rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 transcoder. Code units go in through a queue-style port (push/full) and UTF-8
// bytes come out through another (pop/empty), one byte per item, with last_of_char marking the
// final byte of each character. The front end takes a unit in every cycle while its character
// queue has room; a high surrogate that does not end its string is held and paired with the next
// unit, whatever that unit is, and zero code points produce nothing. The back end serializes one
// byte per cycle while the consumer keeps popping, so a unit yields 1, 2, 3 or 4 bytes according
// to its encoded length (a held high surrogate yields none, and its pair yields 4); the sustained
// rate is set by that byte-wide output serializer. The first byte of a unit is registered in the
// queue, then in cur_reg and out_reg; QUEUE_DEPTH characters can wait between the two ends.
module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  u16u8_pkg::unit_item_t  unit_item,
    input  logic                   pop,
    output logic                   empty,
    output u16u8_pkg::byte_item_t  byte_item
);
    import u16u8_pkg::*;

    logic         q_push;
    logic         q_full;
    logic         q_pop;
    logic         q_empty;
    char_entry_t  q_wr_data;
    char_entry_t  q_rd_data;

    u16u8_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .unit_item (unit_item),
        .q_push    (q_push),
        .q_full    (q_full),
        .q_data    (q_wr_data)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    u16u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rd_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .byte_item (byte_item)
    );

endmodule

### rtl/u16u8_checker.sv
`include "utf16_to_utf8_encoder_assert.svh"

module u16u8_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop,
    input  logic                   empty,
    input  u16u8_pkg::byte_item_t  byte_item
);
    import u16u8_pkg::*;

    // Nothing is offered to the consumer while reset is held.
    `U8_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> empty, "result shown during reset")

    // A result that is not taken stays on the ports unchanged.
    `U8_ASSERT(a_stall_hold, (!empty && !pop) |=> (!empty && $stable(byte_item)), "stalled result changed")

    // Only a lead or continuation byte can be followed by more bytes of the same character.
    `U8_ASSERT(a_inner_high, (!empty && !byte_item.last_of_char) |-> byte_item.utf8_byte[7], "ASCII byte not marked last")

    // A multi-byte lead byte never ends a character.
    `U8_ASSERT(a_last_not_lead, (!empty && byte_item.last_of_char) |-> (byte_item.utf8_byte[7:6] != 2'b11), "lead byte marked last")

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (.*);
